@@ sv/trpd_pkg.sv @@
// ----------------------------------------------------------------------------
// trpd_pkg
// Shared types, constants and the system colour table of the tile row decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

    localparam int NUM_CELLS        = 8;
    localparam int COORD_W          = 9;
    localparam int PAL_AW           = 5;
    localparam int PAL_DEPTH        = 1 << PAL_AW;
    localparam int CIDX_W           = 6;
    localparam int COLOR_TABLE_SIZE = 64;
    localparam int COMP_W           = 8;
    localparam int IN_DATA_W        = 48;
    localparam int OUT_DATA_W       = 48;

    typedef enum logic [1:0] {
        OP_PALETTE    = 2'd0,
        OP_BACKGROUND = 2'd1,
        OP_SPRITE     = 2'd2
    } t_op;

    // one pixel slot of the chain
    typedef struct packed {
        logic                 vis;
        logic                 last;
        logic [PAL_AW-1:0]    addr;
        logic [COORD_W-1:0]   x;
    } t_cell;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } t_rgb;

    function automatic t_rgb sys_colour(input logic [CIDX_W-1:0] idx);
        t_rgb c;
        case (idx)
            6'd0:  c = '{8'h80, 8'h80, 8'h80};  6'd1:  c = '{8'h00, 8'h3D, 8'hA6};
            6'd2:  c = '{8'h00, 8'h12, 8'hB0};  6'd3:  c = '{8'h44, 8'h00, 8'h96};
            6'd4:  c = '{8'hA1, 8'h00, 8'h5E};  6'd5:  c = '{8'hC7, 8'h00, 8'h28};
            6'd6:  c = '{8'hBA, 8'h06, 8'h00};  6'd7:  c = '{8'h8C, 8'h17, 8'h00};
            6'd8:  c = '{8'h5C, 8'h2F, 8'h00};  6'd9:  c = '{8'h10, 8'h45, 8'h00};
            6'd10: c = '{8'h05, 8'h4A, 8'h00};  6'd11: c = '{8'h00, 8'h47, 8'h2E};
            6'd12: c = '{8'h00, 8'h41, 8'h66};  6'd13: c = '{8'h00, 8'h00, 8'h00};
            6'd14: c = '{8'h05, 8'h05, 8'h05};  6'd15: c = '{8'h05, 8'h05, 8'h05};
            6'd16: c = '{8'hC7, 8'hC7, 8'hC7};  6'd17: c = '{8'h00, 8'h77, 8'hFF};
            6'd18: c = '{8'h21, 8'h55, 8'hFF};  6'd19: c = '{8'h82, 8'h37, 8'hFA};
            6'd20: c = '{8'hEB, 8'h2F, 8'hB5};  6'd21: c = '{8'hFF, 8'h29, 8'h50};
            6'd22: c = '{8'hFF, 8'h22, 8'h00};  6'd23: c = '{8'hD6, 8'h32, 8'h00};
            6'd24: c = '{8'hC4, 8'h62, 8'h00};  6'd25: c = '{8'h35, 8'h80, 8'h00};
            6'd26: c = '{8'h05, 8'h8F, 8'h00};  6'd27: c = '{8'h00, 8'h8A, 8'h55};
            6'd28: c = '{8'h00, 8'h99, 8'hCC};  6'd29: c = '{8'h21, 8'h21, 8'h21};
            6'd30: c = '{8'h09, 8'h09, 8'h09};  6'd31: c = '{8'h09, 8'h09, 8'h09};
            6'd32: c = '{8'hFF, 8'hFF, 8'hFF};  6'd33: c = '{8'h0F, 8'hD7, 8'hFF};
            6'd34: c = '{8'h69, 8'hA2, 8'hFF};  6'd35: c = '{8'hD4, 8'h80, 8'hFF};
            6'd36: c = '{8'hFF, 8'h45, 8'hF3};  6'd37: c = '{8'hFF, 8'h61, 8'h8B};
            6'd38: c = '{8'hFF, 8'h88, 8'h33};  6'd39: c = '{8'hFF, 8'h9C, 8'h12};
            6'd40: c = '{8'hFA, 8'hBC, 8'h20};  6'd41: c = '{8'h9F, 8'hE3, 8'h0E};
            6'd42: c = '{8'h2B, 8'hF0, 8'h35};  6'd43: c = '{8'h0C, 8'hF0, 8'hA4};
            6'd44: c = '{8'h05, 8'hFB, 8'hFF};  6'd45: c = '{8'h5E, 8'h5E, 8'h5E};
            6'd46: c = '{8'h0D, 8'h0D, 8'h0D};  6'd47: c = '{8'h0D, 8'h0D, 8'h0D};
            6'd48: c = '{8'hFF, 8'hFF, 8'hFF};  6'd49: c = '{8'hA6, 8'hFC, 8'hFF};
            6'd50: c = '{8'hB3, 8'hEC, 8'hFF};  6'd51: c = '{8'hDA, 8'hAB, 8'hEB};
            6'd52: c = '{8'hFF, 8'hA8, 8'hF9};  6'd53: c = '{8'hFF, 8'hAB, 8'hB3};
            6'd54: c = '{8'hFF, 8'hD2, 8'hB0};  6'd55: c = '{8'hFF, 8'hEF, 8'hA6};
            6'd56: c = '{8'hFF, 8'hF7, 8'h9C};  6'd57: c = '{8'hD7, 8'hE8, 8'h95};
            6'd58: c = '{8'hA6, 8'hED, 8'hAF};  6'd59: c = '{8'hA2, 8'hF2, 8'hDA};
            6'd60: c = '{8'h99, 8'hFF, 8'hFC};  6'd61: c = '{8'hDD, 8'hDD, 8'hDD};
            6'd62: c = '{8'h11, 8'h11, 8'h11};  6'd63: c = '{8'h11, 8'h11, 8'h11};
            default: c = '{8'h00, 8'h00, 8'h00};
        endcase
        return c;
    endfunction

endpackage

@@ sv/trpd_cell.sv @@
// ----------------------------------------------------------------------------
// trpd_cell
// One pixel slot of the shift chain: loads in parallel, else takes its
// upstream neighbour when the head pops.
// ----------------------------------------------------------------------------
module trpd_cell
    import trpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  logic  i_shift,
    input  logic  i_ld_occ,
    input  t_cell i_ld,
    input  logic  i_nb_occ,
    input  t_cell i_nb,
    output logic  o_occ,
    output t_cell o_cell
);

    logic  r_occ;
    t_cell r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_load) begin
            r_occ <= i_ld_occ;
        end else if (i_shift) begin
            r_occ <= i_nb_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cell <= i_ld;
        end else if (i_shift) begin
            r_cell <= i_nb;
        end
    end

    assign o_occ  = r_occ;
    assign o_cell = r_cell;

endmodule

@@ sv/trpd_lookup.sv @@
// ----------------------------------------------------------------------------
// trpd_lookup
// Palette RAM, palette read stage and system colour output register.
// ----------------------------------------------------------------------------
module trpd_lookup
    import trpd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [PAL_AW-1:0]         i_wr_addr,
    input  logic [CIDX_W-1:0]         i_wr_data,
    input  logic                      i_pop,
    input  t_cell                     i_head,
    input  logic [COORD_W-1:0]        i_y,
    output logic                      o_free,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [COORD_W-1:0]        o_x,
    output logic [COORD_W-1:0]        o_y,
    output t_rgb                      o_rgb,
    output logic                      o_last
);

    logic [CIDX_W-1:0]  r_pal [PAL_DEPTH];

    logic               r_a_valid;
    logic [CIDX_W-1:0]  r_a_cidx;
    logic [COORD_W-1:0] r_a_x;
    logic [COORD_W-1:0] r_a_y;
    logic               r_a_last;

    logic               r_o_valid;
    logic [COORD_W-1:0] r_o_x;
    logic [COORD_W-1:0] r_o_y;
    t_rgb               r_o_rgb;
    logic               r_o_last;

    logic               w_o_free;
    logic               w_a_free;

    assign w_o_free = !r_o_valid || i_ready;
    assign w_a_free = !r_a_valid || w_o_free;
    assign o_free   = w_a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAL_DEPTH; i++) begin
                r_pal[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_pal[i_wr_addr] <= i_wr_data;
        end
    end

    // palette read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_free) begin
            r_a_valid <= i_pop && i_head.vis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_free) begin
            r_a_cidx <= r_pal[i_head.addr];
            r_a_x    <= i_head.x;
            r_a_y    <= i_y;
            r_a_last <= i_head.last;
        end
    end

    // colour table stage, holds the beat while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_free) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_free) begin
            r_o_x    <= r_a_x;
            r_o_y    <= r_a_y;
            r_o_rgb  <= sys_colour(r_a_cidx);
            r_o_last <= r_a_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_x     = r_o_x;
    assign o_y     = r_o_y;
    assign o_rgb   = r_o_rgb;
    assign o_last  = r_o_last;

endmodule

@@ sv/tile_row_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// tile_row_pixel_decoder
// Decodes one eight-pixel pattern row into coloured screen pixels.
// ----------------------------------------------------------------------------
// Input stream (s side): one beat per palette write, background row or
// sprite row; tuser carries the operation. Output stream (m side): one beat
// per drawn pixel, tlast on the final pixel of a row.
// A row is decoded into a chain of eight pixel cells in the cycle it is
// accepted; while the receiver does not stall, the head cell pops one
// pixel per cycle into the palette read stage and then into the colour
// output register. A row holds the chain until all eight cells have popped
// (transparent sprite pixels still take their slot), and the next beat is
// accepted in the cycle the last cell pops, so rows stream at one pixel per
// clock without stalls. Palette writes and unused operations wait for the
// same chain slot, so a write never alters pixels of an earlier row.
// Reset (synchronous, active low) clears the palette to zero and empties
// the chain and both stages. When the receiver stalls, the output beat is
// held and, once the palette read stage is full too, the chain stops
// shifting; input is refused while a cell behind the head is occupied or
// the head cannot pop.
// ----------------------------------------------------------------------------
module tile_row_pixel_decoder
    import trpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // plane_low, plane_high, pos_x, pos_y, row_in_tile, attr, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // op
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // pix_x, pix_y, red, green, blue, zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    logic [7:0]         w_lo;
    logic [7:0]         w_hi;
    logic [7:0]         w_px;
    logic [7:0]         w_py;
    logic [2:0]         w_row;
    logic [7:0]         w_attr;
    t_op                w_op;

    logic               w_accept;
    logic               w_load;
    logic               w_pop;
    logic               w_free;
    logic               w_wr;

    logic [NUM_CELLS-1:0] w_occ;
    t_cell              w_cell [NUM_CELLS];
    t_cell              w_ld   [NUM_CELLS];
    logic [NUM_CELLS-1:0] w_vis;
    logic [1:0]         w_bq;
    logic [COORD_W-1:0] w_ld_y;
    logic [COORD_W-1:0] r_y;

    logic [COORD_W-1:0] w_ox;
    logic [COORD_W-1:0] w_oy;
    t_rgb               w_rgb;

    assign w_lo   = i_s_tdata[7:0];
    assign w_hi   = i_s_tdata[15:8];
    assign w_px   = i_s_tdata[23:16];
    assign w_py   = i_s_tdata[31:24];
    assign w_row  = i_s_tdata[34:32];
    assign w_attr = i_s_tdata[42:35];
    assign w_op   = t_op'(i_s_tuser);

    // next beat may go in once the chain is down to its final popping cell
    assign w_pop      = w_occ[0] && w_free;
    assign o_s_tready = !w_occ[1] && (!w_occ[0] || w_pop);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = w_accept && (w_op == OP_BACKGROUND || w_op == OP_SPRITE);
    assign w_wr       = w_accept && (w_op == OP_PALETTE);

    // quadrant palette of the background attribute byte
    always_comb begin
        case ({w_py[1], w_px[1]})
            2'b00:   w_bq = w_attr[1:0];
            2'b01:   w_bq = w_attr[3:2];
            2'b10:   w_bq = w_attr[5:4];
            2'b11:   w_bq = w_attr[7:6];
            default: w_bq = w_attr[1:0];
        endcase
    end

    always_comb begin
        case (w_op)
            OP_BACKGROUND: w_ld_y = {w_py[5:0], w_row};
            OP_SPRITE: begin
                if (w_attr[7]) begin
                    w_ld_y = {1'b0, w_py} + {6'd0, 3'd7 - w_row};
                end else begin
                    w_ld_y = {1'b0, w_py} + {6'd0, w_row};
                end
            end
            default: w_ld_y = '0;
        endcase
    end

    // per-pixel decode; cell k carries bitplane bit k
    always_comb begin
        logic [1:0] v;
        for (int k = 0; k < NUM_CELLS; k++) begin
            v = {w_hi[k], w_lo[k]};
            if (w_op == OP_BACKGROUND) begin
                w_vis[k]       = 1'b1;
                w_ld[k].addr   = (v == 2'd0) ? '0 : {1'b0, w_bq, v};
                w_ld[k].x      = {w_px[5:0], ~3'(k)};
            end else begin
                w_vis[k]       = (v != 2'd0);
                w_ld[k].addr   = {1'b1, w_attr[1:0], v};
                if (w_attr[6]) begin
                    w_ld[k].x  = {1'b0, w_px} + COORD_W'(k);
                end else begin
                    w_ld[k].x  = {1'b0, w_px} + {6'd0, ~3'(k)};
                end
            end
        end
        for (int k = 0; k < NUM_CELLS; k++) begin
            w_ld[k].vis  = w_vis[k];
            w_ld[k].last = w_vis[k] && ((w_vis >> (k + 1)) == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_y <= w_ld_y;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++) begin : g_chain
            logic  w_nb_occ;
            t_cell w_nb;
            if (g == NUM_CELLS - 1) begin : g_tail
                assign w_nb_occ = 1'b0;
                assign w_nb     = '0;
            end else begin : g_mid
                assign w_nb_occ = w_occ[g+1];
                assign w_nb     = w_cell[g+1];
            end
            trpd_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_load   (w_load),
                .i_shift  (w_pop),
                .i_ld_occ (1'b1),
                .i_ld     (w_ld[g]),
                .i_nb_occ (w_nb_occ),
                .i_nb     (w_nb),
                .o_occ    (w_occ[g]),
                .o_cell   (w_cell[g])
            );
        end
    endgenerate

    trpd_lookup u_lookup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr),
        .i_wr_addr (w_px[PAL_AW-1:0]),
        .i_wr_data (w_attr[CIDX_W-1:0]),
        .i_pop     (w_pop),
        .i_head    (w_cell[0]),
        .i_y       (r_y),
        .o_free    (w_free),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_x       (w_ox),
        .o_y       (w_oy),
        .o_rgb     (w_rgb),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, w_rgb.blue, w_rgb.green, w_rgb.red, w_oy, w_ox};

`ifndef SYNTHESIS
    // occupied cells always form a run from the head
    a_occ_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_occ & (w_occ + 8'd1)) == '0)
        else $error("chain occupancy has a gap");

    // at most one pixel of a row in the chain is marked last
    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_cell[7].last && w_occ[7], w_cell[6].last && w_occ[6],
                    w_cell[5].last && w_occ[5], w_cell[4].last && w_occ[4],
                    w_cell[3].last && w_occ[3], w_cell[2].last && w_occ[2],
                    w_cell[1].last && w_occ[1], w_cell[0].last && w_occ[0]}) <= 1)
        else $error("more than one last pixel in chain");

    // a row load fills the whole chain
    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (w_occ == '1))
        else $error("row load did not fill the chain");

    // palette write only lands once the previous row has left the chain
    a_wr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> (w_occ == '0))
        else $error("palette write while pixels still pending");
`endif

endmodule
